// ===== design/nec_tx_pkg.sv =====
// Shared types, constants and helpers of the NEC infrared frame transmitter.
package nec_tx_pkg;

  localparam int FRAME_BITS  = 32;
  localparam int BITS_W      = $clog2(FRAME_BITS + 1);
  localparam int BUTTON_BITS = 5;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  // Request codes carried in the mode field.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SEND  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_DEVICE_ADDRESS     = 3'd0;
  localparam logic [2:0] REG_MARK_LEVEL         = 3'd1;
  localparam logic [2:0] REG_REVERSE_BITS       = 3'd2;
  localparam logic [2:0] REG_SWAP_BYTES         = 3'd3;
  localparam logic [2:0] REG_UNIT_TICKS         = 3'd4;
  localparam logic [2:0] REG_TRAILING_GAP_UNITS = 3'd5;

  // Segment lengths in base units.
  localparam logic [7:0] LEAD_MARK_UNITS  = 8'd16;
  localparam logic [7:0] LEAD_SPACE_UNITS = 8'd8;
  localparam logic [7:0] REP_SPACE_UNITS  = 8'd4;
  localparam logic [7:0] BIT_MARK_UNITS   = 8'd1;
  localparam logic [7:0] ZERO_SPACE_UNITS = 8'd1;
  localparam logic [7:0] ONE_SPACE_UNITS  = 8'd3;
  localparam logic [7:0] STOP_MARK_UNITS  = 8'd1;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_LEAD_MARK  = 4'd1,
    PH_LEAD_SPACE = 4'd2,
    PH_REP_SPACE  = 4'd3,
    PH_BIT_MARK   = 4'd4,
    PH_BIT_SPACE  = 4'd5,
    PH_STOP_MARK  = 4'd6,
    PH_GAP        = 4'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic [BUTTON_BITS-1:0] button;
    logic [7:0]             command;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic dropped;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic        mark_level;
    logic        reverse_bits;
    logic        swap_bytes;
    logic [15:0] unit_ticks;
    logic [7:0]  trailing_gap_units;
  } cfg_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage

// ===== design/nec_tx_regs.sv =====
// APB register file holding the transmitter configuration.
module nec_tx_regs
  import nec_tx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address     <= 8'd0;
      cfg.mark_level         <= 1'b1;
      cfg.reverse_bits       <= 1'b0;
      cfg.swap_bytes         <= 1'b0;
      cfg.unit_ticks         <= 16'd563;
      cfg.trailing_gap_units <= 8'd71;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DEVICE_ADDRESS:     cfg.device_address     <= pwdata[7:0];
        REG_MARK_LEVEL:         cfg.mark_level         <= pwdata[0];
        REG_REVERSE_BITS:       cfg.reverse_bits       <= pwdata[0];
        REG_SWAP_BYTES:         cfg.swap_bytes         <= pwdata[0];
        REG_UNIT_TICKS:         cfg.unit_ticks         <= pwdata[15:0];
        REG_TRAILING_GAP_UNITS: cfg.trailing_gap_units <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DEVICE_ADDRESS:     prdata = APB_DATA_W'(cfg.device_address);
      REG_MARK_LEVEL:         prdata = APB_DATA_W'(cfg.mark_level);
      REG_REVERSE_BITS:       prdata = APB_DATA_W'(cfg.reverse_bits);
      REG_SWAP_BYTES:         prdata = APB_DATA_W'(cfg.swap_bytes);
      REG_UNIT_TICKS:         prdata = APB_DATA_W'(cfg.unit_ticks);
      REG_TRAILING_GAP_UNITS: prdata = APB_DATA_W'(cfg.trailing_gap_units);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== design/nec_tx_engine.sv =====
// Frame sequencer: holds the line state and advances it by one item per step.
module nec_tx_engine
  import nec_tx_pkg::*;
#(
  parameter int UNIT_COUNTER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int CMP_W = (UNIT_COUNTER_BITS > 16) ? UNIT_COUNTER_BITS : 16;

  phase_t                       phase, phase_next;
  logic [UNIT_COUNTER_BITS-1:0] unit_counter, unit_counter_next, cnt_inc;
  logic [7:0]                   units_left, units_left_next, units_dec;
  logic [FRAME_BITS-1:0]        frame_shift, frame_shift_next, frame_word;
  logic [BITS_W-1:0]            bits_left, bits_left_next, bits_dec;
  logic [BUTTON_BITS-1:0]       last_button, last_button_next;
  logic                         last_valid, last_valid_next;
  logic                         drop;
  logic [15:0]                  limit;
  logic                         unit_done;

  // Outcome of finishing the current segment.
  phase_t                       seg_phase;
  logic [7:0]                   seg_units;
  logic [FRAME_BITS-1:0]        seg_shift;
  logic [BITS_W-1:0]            seg_bits;

  logic [7:0] b0, b1, b2, b3, a, c;

  always_comb begin
    a = cfg.device_address;
    c = item.command;
    b0 = a;
    b1 = ~a;
    b2 = c;
    b3 = ~c;
    // Byte swap takes precedence and always sends the bytes unreversed.
    if (cfg.swap_bytes) begin
      b0 = ~c;
      b1 = c;
      b2 = ~a;
      b3 = a;
    end else if (cfg.reverse_bits) begin
      b0 = rev8(a);
      b1 = rev8(~a);
      b2 = rev8(c);
      b3 = rev8(~c);
    end
    frame_word = {b0, b1, b2, b3};
  end

  assign limit     = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
  assign cnt_inc   = unit_counter + 1'b1;
  assign units_dec = units_left - 1'b1;
  assign bits_dec  = bits_left - 1'b1;
  assign unit_done = CMP_W'(cnt_inc) >= CMP_W'(limit);

  always_comb begin
    seg_shift = frame_shift;
    seg_bits  = bits_left;
    unique case (phase)
      PH_LEAD_MARK: begin
        if (bits_left == '0) begin
          seg_phase = PH_REP_SPACE;
          seg_units = REP_SPACE_UNITS;
        end else begin
          seg_phase = PH_LEAD_SPACE;
          seg_units = LEAD_SPACE_UNITS;
        end
      end
      PH_LEAD_SPACE: begin
        seg_phase = PH_BIT_MARK;
        seg_units = BIT_MARK_UNITS;
      end
      PH_REP_SPACE: begin
        seg_phase = PH_STOP_MARK;
        seg_units = STOP_MARK_UNITS;
      end
      PH_BIT_MARK: begin
        seg_phase = PH_BIT_SPACE;
        seg_units = frame_shift[FRAME_BITS-1] ? ONE_SPACE_UNITS : ZERO_SPACE_UNITS;
      end
      PH_BIT_SPACE: begin
        seg_shift = {frame_shift[FRAME_BITS-2:0], 1'b0};
        seg_bits  = bits_dec;
        if (bits_dec == '0) begin
          seg_phase = PH_STOP_MARK;
          seg_units = STOP_MARK_UNITS;
        end else begin
          seg_phase = PH_BIT_MARK;
          seg_units = BIT_MARK_UNITS;
        end
      end
      PH_STOP_MARK: begin
        seg_phase = (cfg.trailing_gap_units == 8'd0) ? PH_IDLE : PH_GAP;
        seg_units = cfg.trailing_gap_units;
      end
      default: begin
        seg_phase = PH_IDLE;
        seg_units = 8'd0;
        seg_shift = '0;
        seg_bits  = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_next        = phase;
    unit_counter_next = unit_counter;
    units_left_next   = units_left;
    frame_shift_next  = frame_shift;
    bits_left_next    = bits_left;
    last_button_next  = last_button;
    last_valid_next   = last_valid;
    drop              = 1'b0;
    if (step) begin
      unique case (item.mode)
        MODE_TICK: begin
          if (phase != PH_IDLE) begin
            if (unit_done) begin
              unit_counter_next = '0;
              units_left_next   = units_dec;
              if (units_dec == 8'd0) begin
                phase_next       = seg_phase;
                units_left_next  = seg_units;
                frame_shift_next = seg_shift;
                bits_left_next   = seg_bits;
              end
            end else begin
              unit_counter_next = cnt_inc;
            end
          end
        end
        MODE_SEND: begin
          if (phase != PH_IDLE) begin
            drop = 1'b1;
          end else begin
            phase_next        = PH_LEAD_MARK;
            units_left_next   = LEAD_MARK_UNITS;
            unit_counter_next = '0;
            if (last_valid && item.button == last_button) begin
              frame_shift_next = '0;
              bits_left_next   = '0;
            end else begin
              frame_shift_next = frame_word;
              bits_left_next   = BITS_W'(FRAME_BITS);
              last_button_next = item.button;
              last_valid_next  = 1'b1;
            end
          end
        end
        MODE_CLEAR: last_valid_next = 1'b0;
        default: ;
      endcase
    end
  end

  // Result of this item, taken from the state after it.
  always_comb begin
    logic mark;
    mark = (phase_next == PH_LEAD_MARK) || (phase_next == PH_BIT_MARK) ||
           (phase_next == PH_STOP_MARK);
    result.line_level = mark ? cfg.mark_level : ~cfg.mark_level;
    result.busy_res   = (phase_next != PH_IDLE);
    result.dropped    = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      unit_counter <= '0;
      units_left   <= '0;
      frame_shift  <= '0;
      bits_left    <= '0;
      last_button  <= '0;
      last_valid   <= 1'b0;
    end else begin
      phase        <= phase_next;
      unit_counter <= unit_counter_next;
      units_left   <= units_left_next;
      frame_shift  <= frame_shift_next;
      bits_left    <= bits_left_next;
      last_button  <= last_button_next;
      last_valid   <= last_valid_next;
    end
  end

endmodule

// ===== design/nec_ir_frame_transmitter.sv =====
// Top level of the NEC infrared frame transmitter.
//
// Each input item is one time tick (mode 0), a send request for a button
// (mode 1) or a clear of the remembered button (mode 2). Every item yields
// exactly one result item: the line level, the busy flag and a flag that a
// send request was refused because a frame was still going out.
// Both channels use valid/stall; an item moves on a rising edge with valid
// high and stall low.
// An accepted item is held in the input register; once the output register
// is free, its result is computed against the sequencer state and loaded
// into the output register, which raises out_valid. One item per cycle is
// sustained while the receiver does not stall.
// While the receiver stalls, the result holds and one more item is still
// taken into the input register; after that in_stall follows out_stall.
// The user writes configuration over the APB port only while the block is
// idle (not enforced). Synchronous reset empties both registers, returns
// the line to idle with no remembered button, and loads register defaults.
module nec_ir_frame_transmitter
  import nec_tx_pkg::*;
#(
  parameter int UNIT_COUNTER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid;
  logic      out_free;
  logic      step;
  out_item_t result;

  assign pready   = 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign step     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  nec_tx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  nec_tx_engine #(
    .UNIT_COUNTER_BITS (UNIT_COUNTER_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

endmodule

// ===== design/nec_tx_checker.sv =====
// Port-level checks of the NEC infrared frame transmitter and their binding.
module nec_tx_props
  import nec_tx_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item,
  input logic      pready
);

  // Nothing leaves the block in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

  // A refused send only happens while a frame is going out.
  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.dropped |-> out_item.busy_res)
    else $error("dropped flagged while idle");

  // The input side only stalls behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind nec_ir_frame_transmitter nec_tx_props u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .pready    (pready)
);

// ===== test/nec_tx_checker.sv =====
// Line-level predictor and result comparison for the NEC infrared frame transmitter.
module nec_tx_checker
  import nec_tx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending,
  output logic                  seq_busy,
  output int                    full_frames,
  output int                    repeat_frames,
  output int                    refused_sends,
  output int                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 100;

  cfg_t                   regs;
  phase_t                 seg;
  logic [15:0]            unit_cnt;
  logic [7:0]             units_rem;
  logic [31:0]            frame_bits;
  logic [5:0]             bits_rem;
  logic [BUTTON_BITS-1:0] held_button;
  logic                   held_ok;
  out_item_t              expected_levels[$];
  int                     fails;
  int                     n_full;
  int                     n_repeat;
  int                     n_refused;
  int                     n_seen;

  function automatic logic [7:0] mirror8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  function automatic void open_segment(input phase_t p, input logic [7:0] n);
    seg = p;
    units_rem = n;
    unit_cnt = '0;
    // A zero trailing gap skips the gap segment entirely.
    if (p == PH_GAP && n == 8'd0) begin
      seg = PH_IDLE;
    end
  endfunction

  function automatic void finish_segment();
    case (seg)
      PH_LEAD_MARK: begin
        if (bits_rem == '0) begin
          open_segment(PH_REP_SPACE, REP_SPACE_UNITS);
        end else begin
          open_segment(PH_LEAD_SPACE, LEAD_SPACE_UNITS);
        end
      end
      PH_LEAD_SPACE: open_segment(PH_BIT_MARK, BIT_MARK_UNITS);
      PH_REP_SPACE:  open_segment(PH_STOP_MARK, STOP_MARK_UNITS);
      PH_BIT_MARK: begin
        open_segment(PH_BIT_SPACE, frame_bits[31] ? ONE_SPACE_UNITS : ZERO_SPACE_UNITS);
      end
      PH_BIT_SPACE: begin
        frame_bits = frame_bits << 1;
        bits_rem = bits_rem - 6'd1;
        if (bits_rem == '0) begin
          open_segment(PH_STOP_MARK, STOP_MARK_UNITS);
        end else begin
          open_segment(PH_BIT_MARK, BIT_MARK_UNITS);
        end
      end
      PH_STOP_MARK: open_segment(PH_GAP, regs.trailing_gap_units);
      default: begin
        open_segment(PH_IDLE, 8'd0);
        frame_bits = '0;
        bits_rem = '0;
      end
    endcase
  endfunction

  function automatic void count_tick();
    logic [16:0] lim;
    lim = (regs.unit_ticks == '0) ? 17'd1 : {1'b0, regs.unit_ticks};
    if (seg != PH_IDLE) begin
      unit_cnt = unit_cnt + 16'd1;
      if ({1'b0, unit_cnt} >= lim) begin
        unit_cnt = '0;
        units_rem = units_rem - 8'd1;
        if (units_rem == '0) begin
          finish_segment();
        end
      end
    end
  endfunction

  function automatic out_item_t predict_line(input in_item_t it);
    out_item_t  r;
    logic [7:0] a;
    logic [7:0] c;
    logic       drop;
    drop = 1'b0;
    a = regs.device_address;
    c = it.command;
    case (it.mode)
      MODE_TICK: count_tick();
      MODE_SEND: begin
        if (seg != PH_IDLE) begin
          drop = 1'b1;
          n_refused++;
        end else if (held_ok && it.button == held_button) begin
          frame_bits = '0;
          bits_rem = '0;
          open_segment(PH_LEAD_MARK, LEAD_MARK_UNITS);
          n_repeat++;
        end else begin
          // Byte swap takes priority and leaves every byte in its natural order.
          if (regs.swap_bytes) begin
            frame_bits = {~c, c, ~a, a};
          end else if (regs.reverse_bits) begin
            frame_bits = {mirror8(a), mirror8(~a), mirror8(c), mirror8(~c)};
          end else begin
            frame_bits = {a, ~a, c, ~c};
          end
          bits_rem = 6'(FRAME_BITS);
          open_segment(PH_LEAD_MARK, LEAD_MARK_UNITS);
          held_button = it.button;
          held_ok = 1'b1;
          n_full++;
        end
      end
      MODE_CLEAR: held_ok = 1'b0;
      default: ;
    endcase
    if (seg == PH_LEAD_MARK || seg == PH_BIT_MARK || seg == PH_STOP_MARK) begin
      r.line_level = regs.mark_level;
    end else begin
      r.line_level = ~regs.mark_level;
    end
    r.busy_res = (seg != PH_IDLE);
    r.dropped = drop;
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input logic want, input logic got);
    if (got !== want) begin
      if (fails < REPORT_CAP) begin
        $error("%s: expected %0b, got %0b", field, want, got);
      end
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      regs.device_address = 8'd0;
      regs.mark_level = 1'b1;
      regs.reverse_bits = 1'b0;
      regs.swap_bytes = 1'b0;
      regs.unit_ticks = 16'd563;
      regs.trailing_gap_units = 8'd71;
      seg = PH_IDLE;
      unit_cnt = '0;
      units_rem = '0;
      frame_bits = '0;
      bits_rem = '0;
      held_button = '0;
      held_ok = 1'b0;
      expected_levels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_DEVICE_ADDRESS:     regs.device_address = pwdata[7:0];
          REG_MARK_LEVEL:         regs.mark_level = pwdata[0];
          REG_REVERSE_BITS:       regs.reverse_bits = pwdata[0];
          REG_SWAP_BYTES:         regs.swap_bytes = pwdata[0];
          REG_UNIT_TICKS:         regs.unit_ticks = pwdata[15:0];
          REG_TRAILING_GAP_UNITS: regs.trailing_gap_units = pwdata[7:0];
          default: ;
        endcase
      end
      // Results are compared before this edge's input is predicted, so a
      // result can never match an expectation created at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          $error("result item arrived with nothing expected");
          fails++;
        end else begin
          want = expected_levels.pop_front();
          note_mismatch("line_level", want.line_level, out_item.line_level);
          note_mismatch("busy_res", want.busy_res, out_item.busy_res);
          note_mismatch("dropped", want.dropped, out_item.dropped);
          n_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_levels.push_back(predict_line(in_item));
      end
    end
    mismatches <= fails;
    pending <= expected_levels.size();
    seq_busy <= (seg != PH_IDLE);
    full_frames <= n_full;
    repeat_frames <= n_repeat;
    refused_sends <= n_refused;
    results_seen <= n_seen;
  end

endmodule

// ===== test/tb_top.sv =====
// Stimulus, clocking and verdict for the NEC infrared frame transmitter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nec_tx_pkg::*;

  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int   mismatches;
  int   pending;
  logic seq_busy;
  int   full_frames;
  int   repeat_frames;
  int   refused_sends;
  int   results_seen;

  int   items_in = 0;
  int   hold_requests = 0;
  int   settings_used = 0;
  bit   calm = 1'b0;
  int   frame_len = 1;
  int   rep_len = 1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nec_ir_frame_transmitter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  nec_tx_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .seq_busy      (seq_busy),
    .full_frames   (full_frames),
    .repeat_frames (repeat_frames),
    .refused_sends (refused_sends),
    .results_seen  (results_seen)
  );

  // Every task below starts and ends right after a rising edge.
  task automatic offer(input logic [1:0] mode, input logic [BUTTON_BITS-1:0] btn,
                       input logic [7:0] cmd);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_item <= '{mode: mode, button: btn, command: cmd};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_in++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Ticks the sequencer until the line is idle and every result has come back.
  task automatic settle_line();
    wait_drained();
    while (seq_busy) begin
      offer(MODE_TICK, BUTTON_BITS'($urandom), 8'($urandom));
    end
    wait_drained();
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic mark, input logic rev,
                            input logic swap, input logic [15:0] ut, input logic [7:0] gap);
    int tpu;
    settle_line();
    cfg_write(REG_DEVICE_ADDRESS, {24'd0, addr});
    cfg_write(REG_MARK_LEVEL, {31'd0, mark});
    cfg_write(REG_REVERSE_BITS, {31'd0, rev});
    cfg_write(REG_SWAP_BYTES, {31'd0, swap});
    cfg_write(REG_UNIT_TICKS, {16'd0, ut});
    cfg_write(REG_TRAILING_GAP_UNITS, {24'd0, gap});
    settings_used++;
    tpu = (ut == 16'd0) ? 1 : int'(ut);
    // Longest full frame has all ones; repeat frames are much shorter.
    frame_len = (int'(LEAD_MARK_UNITS) + int'(LEAD_SPACE_UNITS)
                 + FRAME_BITS * (int'(BIT_MARK_UNITS) + int'(ONE_SPACE_UNITS))
                 + int'(STOP_MARK_UNITS) + int'(gap)) * tpu;
    rep_len = (int'(LEAD_MARK_UNITS) + int'(REP_SPACE_UNITS) + int'(STOP_MARK_UNITS)
               + int'(gap)) * tpu;
  endtask

  // Mostly a send followed by enough ticks to finish its frame, with clears,
  // unused mode codes, early sends and bare tick runs mixed in.
  task automatic run_phase(input int budget, input int max_run);
    int stop_at;
    int run;
    int pick;
    int noise;
    logic [BUTTON_BITS-1:0] btn;
    stop_at = items_in + budget;
    while (items_in < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // A small button set makes repeat frames common.
        btn = ($urandom_range(0, 3) == 0) ? BUTTON_BITS'($urandom_range(0, 31))
                                           : BUTTON_BITS'($urandom_range(0, 2));
        offer(MODE_SEND, btn, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          run = $urandom_range(0, 6);
        end else begin
          run = $urandom_range(rep_len / 2, frame_len + frame_len / 4);
        end
        if (run > max_run) begin
          run = $urandom_range(0, max_run);
        end
        repeat (run) begin
          noise = $urandom_range(0, 99);
          if (noise < 2) begin
            offer(MODE_CLEAR, BUTTON_BITS'($urandom), 8'($urandom));
          end else if (noise < 4) begin
            offer(MODE_NONE, BUTTON_BITS'($urandom), 8'($urandom));
          end else begin
            offer(MODE_TICK, BUTTON_BITS'($urandom), 8'($urandom));
          end
        end
      end else if (pick < 63) begin
        offer(MODE_CLEAR, BUTTON_BITS'($urandom), 8'($urandom));
      end else if (pick < 68) begin
        offer(MODE_NONE, BUTTON_BITS'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 40)) offer(MODE_TICK, BUTTON_BITS'($urandom), 8'($urandom));
      end
    end
  endtask

  // Receiver pacing: short random stall bursts, plus one long hold-off per
  // request so the block fills up and pushes back on its input.
  initial begin : rx_pacing
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("nec_ir_frame_transmitter: mismatch");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: only items that leave the line idle.
    offer(MODE_TICK, '0, 8'h00);
    offer(MODE_NONE, '1, 8'hFF);
    offer(MODE_CLEAR, '0, 8'h00);

    // Swap and reverse both set, zero unit ticks and zero trailing gap.
    set_config(8'hFF, 1'b1, 1'b1, 1'b1, 16'd0, 8'd0);
    offer(MODE_SEND, '1, 8'hFF);
    offer(MODE_SEND, '0, 8'h00);
    offer(MODE_CLEAR, '0, 8'h00);
    offer(MODE_NONE, '0, 8'h00);
    settle_line();
    offer(MODE_SEND, '1, 8'h00);
    repeat (3) offer(MODE_TICK, '1, 8'hFF);
    settle_line();
    offer(MODE_SEND, '1, 8'h5A);
    settle_line();

    // Bit reversal alone with an active-low line.
    set_config(8'h00, 1'b0, 1'b1, 1'b0, 16'd1, 8'd3);
    offer(MODE_SEND, '0, 8'hFF);
    settle_line();
    offer(MODE_SEND, '0, 8'h81);
    settle_line();

    // The frame tails and the settling ticks add roughly as many items again
    // as these budgets.
    set_config(8'h00, 1'b0, 1'b0, 1'b0, 16'd1, 8'd1);
    hold_requests++;
    run_phase(150, 1000000);
    set_config(8'h3C, 1'b1, 1'b1, 1'b0, 16'd2, 8'd0);
    run_phase(130, 1000000);
    set_config(8'hFF, 1'b1, 1'b0, 1'b1, 16'd1, 8'd255);
    run_phase(130, 1000000);
    set_config(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 16'd3,
               8'($urandom_range(0, 8)));
    hold_requests++;
    run_phase(130, 1000000);

    // Last part of the run: no idling on either side.
    calm = 1'b1;
    set_config(8'($urandom), 1'b1, 1'($urandom), 1'($urandom), 16'd0, 8'd6);
    run_phase(130, 1000000);
    set_config(8'($urandom), 1'($urandom), 1'b0, 1'b0, 16'hFFFF, 8'($urandom));
    run_phase(80, 40);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d result items: %0d full frames, %0d repeat frames, %0d refused sends.",
             results_seen, full_frames, repeat_frames, refused_sends);
    $display("Covered %0d register settings, unit ticks from zero to 65535, with stall bursts.",
             settings_used);
    if (mismatches == 0 && pending == 0) begin
      $display("nec_ir_frame_transmitter: match");
    end else begin
      $display("nec_ir_frame_transmitter: mismatch");
    end
    $finish;
  end

endmodule
